// ===== rtl/core/sssb_pkg.sv =====
`timescale 1ns / 1ps

package sssb_pkg;

  // Default number of digit positions held in the store
  localparam int MAX_DIGITS_DEFAULT = 8;

  // Item operations
  localparam logic [1:0] OP_REFRESH = 2'd0;
  localparam logic [1:0] OP_CLEAR   = 2'd1;
  localparam logic [1:0] OP_WRITE   = 2'd2;
  localparam logic [1:0] OP_DOT     = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_DIGITS       = 2'd0;
  localparam logic [1:0] REG_BLINK_FIRST  = 2'd1;
  localparam logic [1:0] REG_BLINK_LAST   = 2'd2;
  localparam logic [1:0] REG_BLINK_PERIOD = 2'd3;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Dot segment of a digit byte
  localparam logic [7:0] DOT_BIT = 8'h80;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] position;
    logic [3:0] bcd_value;
  } cmd_t;

  typedef struct packed {
    logic [7:0] segments;
    logic [2:0] digit_select;
  } res_t;

  // Map a BCD value to segments A..G on bits 0..6; anything above nine is blank
  function automatic logic [7:0] bcd_to_seg(input logic [3:0] value);
    logic [7:0] seg;
    unique case (value)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

// ===== rtl/core/seven_segment_scan_blink.sv =====
`timescale 1ns / 1ps

// Multiplexed seven-segment display controller with digit blinking. The block
// takes one command beat per clock (refresh, clear, write BCD digit, toggle
// dot); each beat is held in the input register and then executed against
// the digit store, and a refresh produces one result beat (segments and
// digit index) through the result register. Throughput is one beat per
// cycle, set by the single input register feeding the digit store and scan
// logic; the command side stalls only while a refresh waits on a stalled
// result register. Configuration writes are taken at any time and should be
// issued only while no command is in flight.

module seven_segment_scan_blink #(
  parameter int MAX_DIGITS = sssb_pkg::MAX_DIGITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sssb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sssb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             cmd_valid,
  output logic                             cmd_stall,
  input  sssb_pkg::cmd_t                   cmd,
  output logic                             res_valid,
  input  logic                             res_stall,
  output sssb_pkg::res_t                   res
);

  logic           s1_valid;
  sssb_pkg::cmd_t s1_item;
  logic           s1_refresh;
  logic           s1_fire;
  logic           res_free;
  sssb_pkg::res_t core_result;

  // Execute the held beat unless its result has nowhere to go
  assign res_free   = !res_valid || !res_stall;
  assign s1_refresh = (s1_item.opcode == sssb_pkg::OP_REFRESH);
  assign s1_fire    = s1_valid && (!s1_refresh || res_free);
  assign cmd_stall  = s1_valid && !s1_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!cmd_stall) begin
      s1_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      s1_item <= cmd;
    end
  end

  sssb_core #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (s1_fire),
    .item      (s1_item),
    .result    (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= s1_fire && s1_refresh;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_refresh) begin
      res <= core_result;
    end
  end

  // A stall is only raised while a beat is held
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> s1_valid)
    else $error("command stall without a held beat");

  // An executed refresh always reaches the result register
  a_refresh_out: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_refresh) |=> res_valid)
    else $error("refresh lost on the way to the result register");

  // Commands other than refresh never raise a result
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_refresh) |=> !$rose(res_valid))
    else $error("result raised by a non-refresh command");

endmodule

// ===== rtl/core/sssb_core.sv =====
`timescale 1ns / 1ps

module sssb_core #(
  parameter int MAX_DIGITS = sssb_pkg::MAX_DIGITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sssb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sssb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             fire,
  input  sssb_pkg::cmd_t                   item,
  output sssb_pkg::res_t                   result
);

  localparam int SCAN_W    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int WIDE_W    = 5;
  localparam int RST_COUNT = (MAX_DIGITS < 8) ? MAX_DIGITS : 8;

  logic [7:0]        digit_store [MAX_DIGITS];
  logic [CNT_W-1:0]  dig_count;
  logic [SCAN_W-1:0] scan_index;
  logic [15:0]       blink_counter;
  logic [2:0]        blink_first;
  logic [2:0]        blink_last;
  logic [15:0]       blink_period;

  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  scan_inc;
  logic [SCAN_W-1:0] scan_next;
  logic [WIDE_W-1:0] scan_wide;
  logic [WIDE_W-1:0] pos_wide;
  logic              pos_ok;
  logic              refresh;
  logic              blink_on;
  logic [16:0]       blink_inc;
  logic [15:0]       blink_next;
  logic              blink_adv;
  logic [15:0]       blink_now;
  logic              blank;

  // Clamp a written digit count to 1..MAX_DIGITS
  always_comb begin
    if (cfg_data[3:0] == 4'd0) begin
      count_next = CNT_W'(1);
    end else if (WIDE_W'(cfg_data[3:0]) > WIDE_W'(MAX_DIGITS)) begin
      count_next = CNT_W'(MAX_DIGITS);
    end else begin
      count_next = CNT_W'(cfg_data[3:0]);
    end
  end

  // Advance the scan, wrapping at the digit count
  assign refresh   = fire && (item.opcode == sssb_pkg::OP_REFRESH);
  assign scan_inc  = CNT_W'(scan_index) + CNT_W'(1);
  assign scan_next = (scan_inc == dig_count) ? '0 : scan_inc[SCAN_W-1:0];
  assign scan_wide = WIDE_W'(scan_next);

  // Step the blink counter once per frame, at digit zero
  assign blink_on   = (blink_period != 16'd0);
  assign blink_inc  = 17'(blink_counter) + 17'd1;
  assign blink_next = (blink_inc == 17'(blink_period)) ? 16'd0 : blink_inc[15:0];
  assign blink_adv  = refresh && blink_on && (scan_next == '0);
  assign blink_now  = blink_adv ? blink_next : blink_counter;

  // Blank digits in the blink range during the second half of the cycle
  assign blank = blink_on
              && (scan_wide >= WIDE_W'(blink_first))
              && (scan_wide <= WIDE_W'(blink_last))
              && (blink_now > (blink_period >> 1));

  assign result.segments     = blank ? 8'h00 : digit_store[scan_next];
  assign result.digit_select = scan_wide[2:0];

  // Writes and toggles only land on digits in use
  assign pos_wide = WIDE_W'(item.position);
  assign pos_ok   = pos_wide < WIDE_W'(dig_count);

  // Scan position, blink counter and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      dig_count     <= CNT_W'(RST_COUNT);
      scan_index    <= SCAN_W'(RST_COUNT - 1);
      blink_counter <= 16'd0;
      blink_first   <= 3'd0;
      blink_last    <= 3'd0;
      blink_period  <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sssb_pkg::REG_DIGITS: begin
          dig_count  <= count_next;
          scan_index <= SCAN_W'(count_next - CNT_W'(1));
        end
        sssb_pkg::REG_BLINK_FIRST: begin
          blink_first   <= cfg_data[2:0];
          blink_counter <= 16'd0;
        end
        sssb_pkg::REG_BLINK_LAST: begin
          blink_last    <= cfg_data[2:0];
          blink_counter <= 16'd0;
        end
        sssb_pkg::REG_BLINK_PERIOD: begin
          blink_period  <= cfg_data;
          blink_counter <= 16'd0;
        end
      endcase
    end else if (refresh) begin
      scan_index <= scan_next;
      if (blink_adv) begin
        blink_counter <= blink_next;
      end
    end
  end

  // Each digit cell updates itself on clear, write or dot toggle
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (rst) begin
        digit_store[i] <= 8'h00;
      end else if (fire) begin
        unique case (item.opcode)
          sssb_pkg::OP_CLEAR: begin
            digit_store[i] <= 8'h00;
          end
          sssb_pkg::OP_WRITE: begin
            if (pos_ok && (pos_wide == WIDE_W'(i))) begin
              digit_store[i] <= sssb_pkg::bcd_to_seg(item.bcd_value);
            end
          end
          sssb_pkg::OP_DOT: begin
            if (pos_ok && (pos_wide == WIDE_W'(i))) begin
              digit_store[i] <= digit_store[i] ^ sssb_pkg::DOT_BIT;
            end
          end
          sssb_pkg::OP_REFRESH: begin
            digit_store[i] <= digit_store[i];
          end
        endcase
      end
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int NUM_DIGITS  = sssb_pkg::MAX_DIGITS_DEFAULT;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 190;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic [sssb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [sssb_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             cmd_valid = 1'b0;
  logic                             cmd_stall;
  sssb_pkg::cmd_t                   cmd = '0;
  logic                             res_valid;
  logic                             res_stall = 1'b0;
  sssb_pkg::res_t                   res;

  seven_segment_scan_blink #(.MAX_DIGITS(NUM_DIGITS)) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  always #5 clk = ~clk;

  // Display model: digit bytes, scan position, blink counter and registers
  logic [7:0]  digit_bytes [NUM_DIGITS];
  logic [2:0]  scan_pos;
  logic [15:0] blink_count;
  logic [3:0]  active_digits;
  logic [2:0]  blink_lo;
  logic [2:0]  blink_hi;
  logic [15:0] blink_len;
  logic [7:0]  seg_image [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                   8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

  sssb_pkg::cmd_t pending_cmds [$];
  sssb_pkg::res_t expected_frames [$];
  int   mismatches = 0;
  int   gap_pct = 0;
  int   stall_pct = 0;
  int   quiet_cycles = 0;

  task automatic reset_display();
    foreach (digit_bytes[i]) digit_bytes[i] = 8'h00;
    active_digits = 4'(NUM_DIGITS);
    scan_pos      = 3'(NUM_DIGITS - 1);
    blink_count   = '0;
    blink_lo      = '0;
    blink_hi      = '0;
    blink_len     = '0;
  endtask

  task automatic set_register(input logic [sssb_pkg::CFG_INDEX_W-1:0] idx,
                              input logic [sssb_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      sssb_pkg::REG_DIGITS: begin
        if (data[3:0] == 4'd0) active_digits = 4'd1;
        else if (data[3:0] > 4'(NUM_DIGITS)) active_digits = 4'(NUM_DIGITS);
        else active_digits = data[3:0];
        scan_pos = 3'(active_digits - 4'd1);
      end
      sssb_pkg::REG_BLINK_FIRST: begin
        blink_lo    = data[2:0];
        blink_count = '0;
      end
      sssb_pkg::REG_BLINK_LAST: begin
        blink_hi    = data[2:0];
        blink_count = '0;
      end
      sssb_pkg::REG_BLINK_PERIOD: begin
        blink_len   = data;
        blink_count = '0;
      end
      default: ;
    endcase
  endtask

  // Apply one accepted command and queue the frame a refresh should emit
  task automatic predict_display(input sssb_pkg::cmd_t c);
    sssb_pkg::res_t frame;
    logic pos_ok;
    pos_ok = c.position < active_digits;
    case (c.opcode)
      sssb_pkg::OP_REFRESH: begin
        scan_pos = 3'((int'(scan_pos) + 1) % int'(active_digits));
        frame.segments     = digit_bytes[scan_pos];
        frame.digit_select = scan_pos;
        if (blink_len != 16'd0) begin
          if (scan_pos == 3'd0)
            blink_count = 16'((int'(blink_count) + 1) % int'(blink_len));
          if (scan_pos >= blink_lo && scan_pos <= blink_hi &&
              blink_count > (blink_len >> 1))
            frame.segments = 8'h00;
        end
        expected_frames.push_back(frame);
      end
      sssb_pkg::OP_CLEAR: begin
        foreach (digit_bytes[i]) digit_bytes[i] = 8'h00;
      end
      sssb_pkg::OP_WRITE: begin
        if (pos_ok)
          digit_bytes[c.position] = (c.bcd_value < 4'd10) ? seg_image[c.bcd_value] : 8'h00;
      end
      sssb_pkg::OP_DOT: begin
        if (pos_ok) digit_bytes[c.position] = digit_bytes[c.position] ^ sssb_pkg::DOT_BIT;
      end
      default: ;
    endcase
  endtask

  function automatic sssb_pkg::cmd_t make_cmd(input logic [1:0] op, input int pos,
                                              input int val);
    sssb_pkg::cmd_t c;
    c.opcode    = op;
    c.position  = 3'(pos);
    c.bcd_value = 4'(val);
    return c;
  endfunction

  // Mostly refreshes and writes; clears kept rare so the store stays populated
  function automatic sssb_pkg::cmd_t random_cmd();
    int             pick;
    sssb_pkg::cmd_t c;
    pick = $urandom_range(99);
    c.position  = 3'($urandom_range(7));
    c.bcd_value = 4'($urandom_range(15));
    if (pick < 45) c.opcode = sssb_pkg::OP_REFRESH;
    else if (pick < 75) c.opcode = sssb_pkg::OP_WRITE;
    else if (pick < 95) c.opcode = sssb_pkg::OP_DOT;
    else c.opcode = sssb_pkg::OP_CLEAR;
    return c;
  endfunction

  // Write all four registers on consecutive edges, upper data bits random except for the period
  task automatic write_setting(input int count, input int first, input int last,
                               input int period);
    logic [sssb_pkg::CFG_DATA_W-1:0] vals [4];
    vals[0] = {12'($urandom), 4'(count)};
    vals[1] = {13'($urandom), 3'(first)};
    vals[2] = {13'($urandom), 3'(last)};
    vals[3] = 16'(period);
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= sssb_pkg::CFG_INDEX_W'(i);
      cfg_data  <= vals[i];
      set_register(sssb_pkg::CFG_INDEX_W'(i), vals[i]);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for the pipeline to drain, then let any non-refresh beat settle
  task automatic wait_idle();
    while (!(pending_cmds.size() == 0 && !cmd_valid && expected_frames.size() == 0))
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Command driver: hold a beat until taken, then maybe idle
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || !cmd_stall) begin
      if (cmd_valid) predict_display(cmd);
      if (pending_cmds.size() != 0 && $urandom_range(99) >= gap_pct) begin
        cmd_valid <= 1'b1;
        cmd       <= pending_cmds.pop_front();
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // Result monitor: compare each frame beat with the oldest expectation
  always @(posedge clk) begin
    sssb_pkg::res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected frame: segments %h digit %0d", res.segments,
                   res.digit_select);
      end else begin
        want = expected_frames.pop_front();
        if (res.segments !== want.segments || res.digit_select !== want.digit_select) begin
          mismatches++;
          if (mismatches <= 10)
            $display("frame mismatch: expected segments %h digit %0d, got segments %h digit %0d",
                     want.segments, want.digit_select, res.segments, res.digit_select);
        end
      end
    end
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: give up after a long stretch with no beat moving
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int settings [8][4] = '{
      '{8, 0, 7, 3},        // all digits blink
      '{0, 0, 0, 2},        // zero count taken as one
      '{15, 5, 2, 3},       // oversized count, empty blink range
      '{3, 1, 2, 4},
      '{1, 0, 7, 65535},    // longest period
      '{5, 0, 4, 1},        // shortest period
      '{8, 7, 7, 5},
      '{6, 2, 5, 0}         // blinking off
    };
    int values [8] = '{0, 9, 10, 15, 8, 1, 7, 5};

    reset_display();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: value extremes, dot toggles, full scan, clear, write over a dot
    for (int p = 0; p < 8; p++)
      pending_cmds.push_back(make_cmd(sssb_pkg::OP_WRITE, p, values[p]));
    pending_cmds.push_back(make_cmd(sssb_pkg::OP_DOT, 0, 0));
    pending_cmds.push_back(make_cmd(sssb_pkg::OP_DOT, 7, 15));
    for (int i = 0; i < 8; i++)
      pending_cmds.push_back(make_cmd(sssb_pkg::OP_REFRESH, i, i));
    pending_cmds.push_back(make_cmd(sssb_pkg::OP_CLEAR, 0, 0));
    pending_cmds.push_back(make_cmd(sssb_pkg::OP_DOT, 4, 0));
    pending_cmds.push_back(make_cmd(sssb_pkg::OP_WRITE, 4, 3));
    for (int i = 0; i < 5; i++)
      pending_cmds.push_back(make_cmd(sssb_pkg::OP_REFRESH, 7, 15));
    wait_idle();

    // Random phases, each under its own register setting and one of four idling modes
    for (int ph = 0; ph < 8; ph++) begin
      gap_pct   = 0;
      stall_pct = 0;
      write_setting(settings[ph][0], settings[ph][1], settings[ph][2], settings[ph][3]);
      case (ph % 4)
        1: gap_pct = 51;
        2: stall_pct = 51;
        3: begin
          gap_pct   = 28;
          stall_pct = 28;
        end
        default: ;
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) pending_cmds.push_back(random_cmd());
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_frames.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sssb_pkg.sv
rtl/core/sssb_core.sv
rtl/core/seven_segment_scan_blink.sv
bench/tb.sv
